// File: design/irc_line_tokenizer_top_macros.svh
// ----------------------------------------------------------------------------
// irc_line_tokenizer_top_macros.svh
// Assertion macros used by the tokenizer top module.
// ----------------------------------------------------------------------------
`ifndef IRC_LINE_TOKENIZER_TOP_MACROS_SVH
`define IRC_LINE_TOKENIZER_TOP_MACROS_SVH

// Condition that must hold on every clock edge outside reset
`define IRCLT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define IRCLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/irclt_pkg.sv
// ----------------------------------------------------------------------------
// irclt_pkg
// Types, byte codes and the command name table of the line tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package irclt_pkg;

  // Longest line that is tokenized; later bytes are tagged ignored
  localparam int MAX_LINE = 512;
  localparam int POS_W    = $clog2(MAX_LINE + 1);

  localparam int NUM_CMDS  = 11;
  localparam int CMD_BYTES = 7;

  localparam logic [7:0] BYTE_COLON = 8'h3A;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LC_A  = 8'h61;
  localparam logic [7:0] BYTE_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  localparam logic [3:0] CODE_NONE    = 4'd0;
  localparam logic [3:0] CODE_PRIVMSG = 4'd5;
  localparam logic [3:0] LEN_TOO_LONG = 4'd8;
  localparam logic [7:0] COUNT_MAX    = 8'd255;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_PREFIX = 3'd1,
    PH_CMD    = 3'd2,
    PH_PARAMS = 3'd3,
    PH_REST   = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_WS     = 3'd0,
    ROLE_PREFIX = 3'd1,
    ROLE_CMD    = 3'd2,
    ROLE_PARAM  = 3'd3,
    ROLE_COLON  = 3'd4,
    ROLE_IGNORE = 3'd5
  } role_t;

  // Command names, first character in the lowest byte
  localparam logic [8*CMD_BYTES-1:0] CMD_CHARS [NUM_CMDS] = '{
    56'h0000_0053_534150,   // PASS
    56'h0000_004B_43494E,   // NICK
    56'h0000_0052_455355,   // USER
    56'h0000_004E_494F4A,   // JOIN
    56'h4753_4D56_495250,   // PRIVMSG
    56'h0000_4349_504F54,   // TOPIC
    56'h0000_0045_444F4D,   // MODE
    56'h0045_5449_564E49,   // INVITE
    56'h0000_0054_524150,   // PART
    56'h0000_004B_43494B,   // KICK
    56'h0000_0054_495551    // QUIT
  };

  localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd7, 4'd5, 4'd4, 4'd6, 4'd4, 4'd4, 4'd4
  };

  // Match a collected command word against the name table
  function automatic logic [3:0] cmd_lookup(input logic [8*CMD_BYTES-1:0] chars,
                                            input logic [3:0] len);
    logic [3:0] code;
    code = CODE_NONE;
    for (int i = 0; i < NUM_CMDS; i++) begin
      if (len == CMD_LEN[i] && chars == CMD_CHARS[i]) begin
        code = 4'(i + 1);
      end
    end
    return code;
  endfunction

endpackage

// File: design/irc_line_tokenizer_top.sv
// ----------------------------------------------------------------------------
// irc_line_tokenizer_top
// Byte-serial tokenizer for one chat-protocol message line.
//
//  channel   dir  fields (tdata / tuser / tlast)
//  s_axis    in   line_byte / - / end_of_line
//  m_axis    out  param_index, word_start, command_code, line_valid,
//                 param_count / role / line_done
//
// One item per cycle sustained while the result is not stalled; each item passes
// through the input register and leaves through the result register.
// The running line state updates as the item moves into the result register.
// A stalled result holds the input register; s_axis_tready follows from it.
// rst clears the valid flags and the line state; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "irc_line_tokenizer_top_macros.svh"

module irc_line_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
  input  logic        s_axis_tlast,   // end_of_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] param_index, [8] word_start,
                                      // [12:9] command_code, [13] line_valid,
                                      // [21:14] param_count, [23:22] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] role
  output logic        m_axis_tlast    // line_done
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eol;

  // Result register
  logic       out_valid;
  logic [2:0] out_role;
  logic [7:0] out_index;
  logic       out_start;
  logic       out_done;
  logic [3:0] out_code;
  logic       out_line_valid;
  logic [7:0] out_count;

  // Line state
  irclt_pkg::phase_t                phase, phase_next;
  logic                             in_word, in_word_next;
  logic [8*irclt_pkg::CMD_BYTES-1:0] command_chars, command_chars_next;
  logic [3:0]                       command_length, command_length_next;
  logic [3:0]                       command_value, command_value_next;
  logic [7:0]                       params_seen, params_seen_next;
  logic [7:0]                       cur_index, cur_index_next;
  logic [irclt_pkg::POS_W-1:0]      line_pos, line_pos_next;

  // Per-item results
  irclt_pkg::role_t role_c;
  logic [7:0]       index_c;
  logic             start_c;
  logic [3:0]       code_c;
  logic             line_valid_c;
  logic [7:0]       count_c;

  logic       advance;
  logic       is_ws;
  logic       do_append;
  logic       do_finish;
  logic [7:0] upper_byte;
  logic [3:0] lookup_code;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_eol  <= s_axis_tlast;
    end
  end

  // Classify the byte
  assign is_ws = (in_byte == irclt_pkg::BYTE_SPACE) ||
                 (in_byte >= irclt_pkg::BYTE_TAB && in_byte <= irclt_pkg::BYTE_CR);
  assign upper_byte = (in_byte >= irclt_pkg::BYTE_LC_A && in_byte <= irclt_pkg::BYTE_LC_Z)
                      ? in_byte - irclt_pkg::CASE_DIFF : in_byte;

  // Next state and result fields
  always_comb begin
    phase_next          = phase;
    in_word_next        = in_word;
    command_chars_next  = command_chars;
    command_length_next = command_length;
    command_value_next  = command_value;
    params_seen_next    = params_seen;
    cur_index_next      = cur_index;
    line_pos_next       = line_pos;
    role_c              = irclt_pkg::ROLE_IGNORE;
    index_c             = '0;
    start_c             = 1'b0;
    do_append           = 1'b0;
    do_finish           = 1'b0;

    if (line_pos < irclt_pkg::POS_W'(irclt_pkg::MAX_LINE)) begin
      line_pos_next = line_pos + 1'b1;
      unique case (phase)
        irclt_pkg::PH_FIRST: begin
          if (is_ws) begin
            role_c = irclt_pkg::ROLE_WS;
          end else if (in_byte == irclt_pkg::BYTE_COLON) begin
            phase_next   = irclt_pkg::PH_PREFIX;
            in_word_next = 1'b1;
            role_c       = irclt_pkg::ROLE_PREFIX;
            start_c      = 1'b1;
          end else begin
            do_append  = 1'b1;
            phase_next = irclt_pkg::PH_CMD;
            role_c     = irclt_pkg::ROLE_CMD;
            start_c    = 1'b1;
          end
        end
        irclt_pkg::PH_PREFIX: begin
          if (is_ws) begin
            in_word_next = 1'b0;
            role_c       = irclt_pkg::ROLE_WS;
          end else if (in_word) begin
            role_c = irclt_pkg::ROLE_PREFIX;
          end else begin
            do_append  = 1'b1;
            phase_next = irclt_pkg::PH_CMD;
            role_c     = irclt_pkg::ROLE_CMD;
            start_c    = 1'b1;
          end
        end
        irclt_pkg::PH_CMD: begin
          if (is_ws) begin
            do_finish    = 1'b1;
            phase_next   = irclt_pkg::PH_PARAMS;
            in_word_next = 1'b0;
            role_c       = irclt_pkg::ROLE_WS;
          end else begin
            do_append = 1'b1;
            role_c    = irclt_pkg::ROLE_CMD;
          end
        end
        irclt_pkg::PH_PARAMS: begin
          if (is_ws) begin
            in_word_next = 1'b0;
            role_c       = irclt_pkg::ROLE_WS;
          end else if (in_word) begin
            role_c  = irclt_pkg::ROLE_PARAM;
            index_c = cur_index;
          end else begin
            // open a new parameter
            cur_index_next = params_seen;
            if (params_seen != irclt_pkg::COUNT_MAX) begin
              params_seen_next = params_seen + 1'b1;
            end
            index_c = params_seen;
            start_c = 1'b1;
            if (in_byte == irclt_pkg::BYTE_COLON) begin
              role_c     = irclt_pkg::ROLE_COLON;
              phase_next = irclt_pkg::PH_REST;
            end else if (command_value == irclt_pkg::CODE_PRIVMSG && params_seen == 8'd1) begin
              role_c     = irclt_pkg::ROLE_PARAM;
              phase_next = irclt_pkg::PH_REST;
            end else begin
              role_c       = irclt_pkg::ROLE_PARAM;
              in_word_next = 1'b1;
            end
          end
        end
        irclt_pkg::PH_REST: begin
          if (in_byte == irclt_pkg::BYTE_LF) begin
            phase_next = irclt_pkg::PH_DONE;
          end else begin
            role_c  = irclt_pkg::ROLE_PARAM;
            index_c = cur_index;
          end
        end
        irclt_pkg::PH_DONE: begin
          role_c = irclt_pkg::ROLE_IGNORE;
        end
        default: begin
          role_c = irclt_pkg::ROLE_IGNORE;
        end
      endcase
    end

    // Collect the upper-cased command byte; length saturates at too long
    if (do_append) begin
      for (int k = 0; k < irclt_pkg::CMD_BYTES; k++) begin
        if (command_length == 4'(k)) begin
          command_chars_next[8*k +: 8] = upper_byte;
        end
      end
      if (command_length < irclt_pkg::LEN_TOO_LONG) begin
        command_length_next = command_length + 1'b1;
      end
    end

    lookup_code = irclt_pkg::cmd_lookup(command_chars_next, command_length_next);
    if (do_finish) begin
      command_value_next = lookup_code;
    end

    // Line summary, reported on the final byte only
    code_c       = irclt_pkg::CODE_NONE;
    line_valid_c = 1'b0;
    count_c      = '0;
    if (in_eol && (phase_next == irclt_pkg::PH_CMD || phase_next == irclt_pkg::PH_PARAMS ||
                   phase_next == irclt_pkg::PH_REST || phase_next == irclt_pkg::PH_DONE)) begin
      code_c       = (phase_next == irclt_pkg::PH_CMD) ? lookup_code : command_value_next;
      line_valid_c = 1'b1;
      count_c      = params_seen_next;
    end

    // Return to reset after the final byte
    if (in_eol) begin
      phase_next          = irclt_pkg::PH_FIRST;
      in_word_next        = 1'b0;
      command_chars_next  = '0;
      command_length_next = '0;
      command_value_next  = irclt_pkg::CODE_NONE;
      params_seen_next    = '0;
      cur_index_next      = '0;
      line_pos_next       = '0;
    end
  end

  // Hold the line state between items
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= irclt_pkg::PH_FIRST;
      in_word        <= 1'b0;
      command_chars  <= '0;
      command_length <= '0;
      command_value  <= irclt_pkg::CODE_NONE;
      params_seen    <= '0;
      cur_index      <= '0;
      line_pos       <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      in_word        <= in_word_next;
      command_chars  <= command_chars_next;
      command_length <= command_length_next;
      command_value  <= command_value_next;
      params_seen    <= params_seen_next;
      cur_index      <= cur_index_next;
      line_pos       <= line_pos_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_role       <= role_c;
      out_index      <= index_c;
      out_start      <= start_c;
      out_done       <= in_eol;
      out_code       <= code_c;
      out_line_valid <= line_valid_c;
      out_count      <= count_c;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_role;
  assign m_axis_tlast  = out_done;
  assign m_axis_tdata  = {2'b00, out_count, out_line_valid, out_code, out_start, out_index};

  // Checks
  `IRCLT_ASSERT_ALWAYS(a_summary_only_at_end,
    !(out_valid && !out_done) || (out_code == irclt_pkg::CODE_NONE && !out_line_valid &&
                                  out_count == 8'd0),
    "line summary set on a byte that does not end the line")
  `IRCLT_ASSERT_ALWAYS(a_index_only_in_params,
    !(out_valid && out_role != irclt_pkg::ROLE_PARAM && out_role != irclt_pkg::ROLE_COLON)
      || out_index == 8'd0,
    "parameter index set outside a parameter")
  `IRCLT_ASSERT_NEXT(a_stall_keeps_item,
    in_valid && out_valid && !m_axis_tready,
    in_valid && $stable(in_byte) && $stable(in_eol),
    "input item lost while the result stalls")
  `IRCLT_ASSERT_NEXT(a_line_end_resets,
    advance && in_eol,
    phase == irclt_pkg::PH_FIRST && params_seen == 8'd0 && line_pos == '0,
    "line state not cleared after the final byte")

endmodule

// File: bench/tb_tokenizer_pkg.sv
// ----------------------------------------------------------------------------
// tb_tokenizer_pkg
// Line tokenizer predictor and scoreboard for the bench.
//
// The scoreboard keeps its own copy of the running line state. Every accepted
// input byte is tokenized here and the expected result is queued; every
// accepted result is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tb_tokenizer_pkg;

  import irclt_pkg::*;

  // Expected content of one result item
  typedef struct packed {
    role_t       role;
    logic [7:0]  param_idx;
    logic        start;
    logic        done;
    logic [3:0]  code;
    logic        valid;
    logic [7:0]  count;
  } tok_result_t;

  // C whitespace set: TAB, LF, VT, FF, CR and SPACE
  function automatic logic is_space(logic [7:0] b);
    return (b == BYTE_SPACE) || (b >= BYTE_TAB && b <= BYTE_CR);
  endfunction

  // Command spelling for codes 1 to 11
  function automatic string command_word(int code);
    case (code)
      1:       return "PASS";
      2:       return "NICK";
      3:       return "USER";
      4:       return "JOIN";
      5:       return "PRIVMSG";
      6:       return "TOPIC";
      7:       return "MODE";
      8:       return "INVITE";
      9:       return "PART";
      10:      return "KICK";
      11:      return "QUIT";
      default: return "";
    endcase
  endfunction

  class tok_scoreboard;

    tok_result_t expected_q[$];
    int          mismatches;
    int          results_seen;

    // Running line state
    phase_t      ph;
    logic        in_word;
    logic [55:0] cmd_chars;
    logic [3:0]  cmd_len;
    logic [3:0]  cmd_code;
    logic [7:0]  params_seen;
    logic [7:0]  cur_param;
    int          line_pos;

    function new();
      mismatches   = 0;
      results_seen = 0;
      clear_line();
    endfunction

    function void clear_line();
      ph          = PH_FIRST;
      in_word     = 1'b0;
      cmd_chars   = '0;
      cmd_len     = '0;
      cmd_code    = CODE_NONE;
      params_seen = '0;
      cur_param   = '0;
      line_pos    = 0;
    endfunction

    // Upper-case and collect one command byte; length sticks at too long
    function void push_char(logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (c >= BYTE_LC_A && c <= BYTE_LC_Z) begin
        c = c - CASE_DIFF;
      end
      if (cmd_len < 4'(CMD_BYTES)) begin
        cmd_chars[8*cmd_len +: 8] = c;
      end
      if (cmd_len < LEN_TOO_LONG) begin
        cmd_len = cmd_len + 4'd1;
      end
    endfunction

    // Look the collected word up by spelling and length
    function void close_command();
      string w;
      logic  same;
      cmd_code = CODE_NONE;
      if (cmd_len == 4'd0 || cmd_len > 4'(CMD_BYTES)) begin
        return;
      end
      for (int i = 1; i <= NUM_CMDS; i++) begin
        w = command_word(i);
        same = (w.len() == int'(cmd_len));
        for (int k = 0; k < w.len() && same; k++) begin
          if (cmd_chars[8*k +: 8] != w[k]) begin
            same = 1'b0;
          end
        end
        if (same) begin
          cmd_code = 4'(i);
          return;
        end
      end
    endfunction

    // Tokenize one accepted byte and queue the result it must give
    function void note_input(logic [7:0] b, logic eol);
      tok_result_t want;
      logic        ws;
      ws = is_space(b);
      want = '0;
      want.role = ROLE_IGNORE;
      want.done = eol;
      if (line_pos < MAX_LINE) begin
        line_pos++;
        case (ph)
          PH_FIRST: begin
            if (ws) begin
              want.role = ROLE_WS;
            end else if (b == BYTE_COLON) begin
              ph = PH_PREFIX;
              in_word = 1'b1;
              want.role = ROLE_PREFIX;
              want.start = 1'b1;
            end else begin
              push_char(b);
              ph = PH_CMD;
              want.role = ROLE_CMD;
              want.start = 1'b1;
            end
          end
          PH_PREFIX: begin
            if (ws) begin
              in_word = 1'b0;
              want.role = ROLE_WS;
            end else if (in_word) begin
              want.role = ROLE_PREFIX;
            end else begin
              push_char(b);
              ph = PH_CMD;
              want.role = ROLE_CMD;
              want.start = 1'b1;
            end
          end
          PH_CMD: begin
            if (ws) begin
              close_command();
              ph = PH_PARAMS;
              in_word = 1'b0;
              want.role = ROLE_WS;
            end else begin
              push_char(b);
              want.role = ROLE_CMD;
            end
          end
          PH_PARAMS: begin
            if (ws) begin
              in_word = 1'b0;
              want.role = ROLE_WS;
            end else if (in_word) begin
              want.role = ROLE_PARAM;
              want.param_idx = cur_param;
            end else begin
              // New parameter: count it, saturating
              cur_param = params_seen;
              if (params_seen < COUNT_MAX) begin
                params_seen = params_seen + 8'd1;
              end
              want.param_idx = cur_param;
              want.start = 1'b1;
              if (b == BYTE_COLON) begin
                want.role = ROLE_COLON;
                ph = PH_REST;
              end else if (cmd_code == CODE_PRIVMSG && cur_param == 8'd1) begin
                want.role = ROLE_PARAM;
                ph = PH_REST;
              end else begin
                want.role = ROLE_PARAM;
                in_word = 1'b1;
              end
            end
          end
          PH_REST: begin
            if (b == BYTE_LF) begin
              ph = PH_DONE;
              want.role = ROLE_IGNORE;
            end else begin
              want.role = ROLE_PARAM;
              want.param_idx = cur_param;
            end
          end
          default: begin
            want.role = ROLE_IGNORE;
          end
        endcase
      end
      // Summary fields on the final byte, then start a fresh line
      if (eol) begin
        if (ph == PH_CMD) begin
          close_command();
        end
        if (ph != PH_FIRST && ph != PH_PREFIX) begin
          want.code  = cmd_code;
          want.valid = 1'b1;
          want.count = params_seen;
        end
        clear_line();
      end
      expected_q.insert(expected_q.size(), want);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("tb_top: result %0d %s mismatch: got %0d, expected %0d",
               results_seen, what, got, want);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(logic [23:0] data, logic [2:0] user, logic last);
      tok_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
        results_seen++;
        return;
      end
      want = expected_q.pop_front();
      if (user != want.role) report_mismatch("role", user, want.role);
      if (data[7:0] != want.param_idx) report_mismatch("param_index", data[7:0], want.param_idx);
      if (data[8] != want.start) report_mismatch("word_start", data[8], want.start);
      if (data[12:9] != want.code) report_mismatch("command_code", data[12:9], want.code);
      if (data[13] != want.valid) report_mismatch("line_valid", data[13], want.valid);
      if (data[21:14] != want.count) report_mismatch("param_count", data[21:14], want.count);
      if (data[23:22] != 2'b00) report_mismatch("pad bits", data[23:22], 0);
      if (last != want.done) report_mismatch("line_done", last, want.done);
      results_seen++;
    endtask

  endclass

endpackage

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream bench for the chat line tokenizer.
//
// Feeds whole message lines, one byte per item, first a handful of hand-made
// lines and then random lines: mostly well-formed with random content, plus
// noise, truncated lines and two long lines, one past the length limit. Both
// stream sides idle at random; the receiver once holds off for a long
// stretch. Results are checked against the scoreboard's own tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import irclt_pkg::*;
  import tb_tokenizer_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 4;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 10;
  localparam int CYCLE_LIMIT    = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  tok_scoreboard sb = new();

  logic [7:0] line_q[$];
  bit         no_idle = 1'b0;
  bit         rx_hold = 1'b0;
  int         bytes_sent = 0;
  int         cycle_count = 0;

  irc_line_tokenizer_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  always #(CLK_HALF) clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Note accepted input items and check accepted results
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sb.note_input(s_tdata, s_tlast);
    end
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  // Wait cycles before the next item on either side
  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return $urandom_range(1, 18);
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (is_space(b));
    return b;
  endfunction

  // Receiver: random stalls, and one long hold-off on request
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task send_byte(logic [7:0] b, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Append one byte to the line being built
  task add_byte(logic [7:0] b);
    line_q.insert(line_q.size(), b);
  endtask

  // Send the built line, marking its final byte
  task send_line();
    for (int i = 0; i < line_q.size(); i++) begin
      send_byte(line_q[i], i == line_q.size() - 1);
    end
    line_q.delete();
  endtask

  task add_spaces();
    int k;
    repeat ($urandom_range(1, 3)) begin
      k = $urandom_range(0, 5);
      add_byte(k == 5 ? BYTE_SPACE : BYTE_TAB + 8'(k));
    end
  endtask

  task add_word(int n);
    repeat (n) add_byte(word_byte());
  endtask

  // Append text; letters flip to lower case at random when asked
  task add_text(string s, bit mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) begin
        c = c + CASE_DIFF;
      end
      add_byte(c);
    end
  endtask

  // One random line: well-formed most of the time, else noise or truncated
  task build_line();
    int kind;
    int pick;
    int keep;
    kind = $urandom_range(0, 99);
    if (kind >= 70 && kind < 90) begin
      repeat ($urandom_range(1, 24)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) add_spaces();
    if ($urandom_range(0, 9) < 4) begin
      add_byte(BYTE_COLON);
      add_word($urandom_range(0, 8));
      add_spaces();
    end
    pick = $urandom_range(0, 19);
    if (pick < 4) begin
      add_text(command_word(CODE_PRIVMSG), 1'b1);
    end else if (pick < 14) begin
      add_text(command_word($urandom_range(1, NUM_CMDS)), 1'b1);
    end else if (pick < 17) begin
      add_word($urandom_range(1, 9));
    end else begin
      // Known name with extra letters: no match or too long
      add_text(command_word($urandom_range(1, NUM_CMDS)), 1'b1);
      add_word($urandom_range(1, 3));
    end
    repeat ($urandom_range(0, 6)) begin
      add_spaces();
      if ($urandom_range(0, 4) == 0) begin
        // Trailing parameter, sometimes with a newline and bytes after it
        add_byte(BYTE_COLON);
        repeat ($urandom_range(0, 10)) add_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) < 3) begin
          add_byte(BYTE_LF);
          repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
        end
        break;
      end
      add_word($urandom_range(1, 6));
    end
    if ($urandom_range(0, 3) == 0) add_spaces();
    if (kind >= 90) begin
      keep = $urandom_range(1, line_q.size());
      while (line_q.size() > keep) void'(line_q.pop_back());
    end
  endtask

  // Command and one-byte parameters, cut to the given total; may run past the length limit
  task build_long_line(int total);
    add_text(command_word($urandom_range(1, NUM_CMDS)), 1'b1);
    while (line_q.size() < total) begin
      add_byte(BYTE_SPACE);
      add_byte(word_byte());
    end
    while (line_q.size() > total) void'(line_q.pop_back());
  endtask

  // Stop offering items and wait until every result is out
  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    int line_no;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hand-made lines: prefix with rest-of-line text and a newline,
    // command case, long command word, blank line, lone prefix, lone bytes
    add_text(":n!u@h PRIVMSG #a hi you\nzz", 1'b0);
    send_line();
    add_text("privmsg b :x y", 1'b0);
    send_line();
    add_text("QuIt :\n", 1'b0);
    send_line();
    add_text("PRIVMSGX a", 1'b0);
    send_line();
    add_byte(BYTE_SPACE);
    add_byte(BYTE_TAB);
    add_byte(BYTE_CR);
    send_line();
    add_text(":only", 1'b0);
    send_line();
    add_byte(8'hFF);
    send_line();
    add_byte(8'h00);
    send_line();

    // Let every result out before the random part
    drain();

    line_no = 0;
    while (bytes_sent < RANDOM_ITEMS) begin
      if (line_no % 25 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (line_no == 20) begin
        rx_hold = 1'b1;
      end
      if (line_no == 15) begin
        drain();
      end
      if (line_no == 10) begin
        build_long_line(2 * COUNT_MAX + 1);
        send_line();
      end
      if (line_no == 25) begin
        build_long_line(MAX_LINE + 28);
        send_line();
      end
      build_line();
      send_line();
      line_no++;
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
